// ===== hdl/ctrle_pkg.sv =====
package ctrle_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned COL_W     = 9;
    localparam int unsigned ROW_W     = 6;
    localparam int unsigned COUNT_W   = 7;
    localparam int unsigned CFG_W     = 9;
    localparam int unsigned CFG_MAX   = 511;
    localparam int unsigned OUT_DATA_W = 24;
    localparam int unsigned OUT_USER_W = 2;

    localparam logic [ROW_W-1:0] ROW_LAST = 6'h3F;

    typedef enum logic [1:0] {
        CODE_LITERAL = 2'b00,
        CODE_SHORT   = 2'b01,
        CODE_ZERO    = 2'b10,
        CODE_SINGLE  = 2'b11
    } code_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

endpackage

// ===== hdl/column_tile_rle_decoder.sv =====
// Run-length decoder for a column-major tile map of 64 rows per column. Each
// accepted word on the slave side is one byte of the compressed stream (or,
// with tuser set, the end of the stream); each word on the master side is one
// tile with its column and row, or one error word flagged in tuser when the
// stream ended before the map was full. A byte that starts a run holds tready
// low while one shared position and count unit emits its N tiles (N up to 64)
// at one tile per cycle whenever the master side can take a word; a stall on
// the master side holds the run. Literal headers, zero-length runs and bytes
// after the map is full start no run and leave tready high. map_columns is
// taken from cfg_wr_data when cfg_wr_en is high; 0 acts as 1 and values
// above MAX_COLUMNS act as MAX_COLUMNS.
module column_tile_rle_decoder
    import ctrle_pkg::*;
#(
    parameter int unsigned MAX_COLUMNS = 256
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_W-1:0]       cfg_wr_data,     // map_columns
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [BYTE_W-1:0]      s_axis_tdata,    // code_byte
    input  logic                   s_axis_tuser,    // stream_end
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,    // tile_value, column_index, row_index, 0
    output logic                   m_axis_tlast,    // run_last
    output logic [OUT_USER_W-1:0]  m_axis_tuser     // map_complete, truncated
);

    localparam int unsigned CLAMP = (MAX_COLUMNS > CFG_MAX) ? CFG_MAX : MAX_COLUMNS;
    localparam logic [COL_W-1:0] CLAMP_L = COL_W'(CLAMP);

    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     map_columns_reg, map_columns_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic                 lit_pending_reg, lit_pending_next;
    logic [COUNT_W-1:0]   lit_count_reg, lit_count_next;
    logic                 finished_reg, finished_next;
    logic [COUNT_W-1:0]   run_count_reg, run_count_next;
    logic [BYTE_W-1:0]    run_value_reg, run_value_next;
    logic                 run_trunc_reg, run_trunc_next;

    logic                 m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]    out_value_reg, out_value_next;
    logic [7:0]           out_col_reg, out_col_next;
    logic [ROW_W-1:0]     out_row_reg, out_row_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_done_reg, out_done_next;
    logic                 out_trunc_reg, out_trunc_next;

    logic                 in_accept;
    logic                 slot_free;
    logic [COL_W-1:0]     eff_cols;
    logic [COL_W-1:0]     col_inc;
    code_t                code;
    logic                 run_go;
    logic [COUNT_W-1:0]   run_n;
    logic [BYTE_W-1:0]    run_v;
    logic                 rearm;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !m_valid_reg || m_axis_tready;
    assign code          = code_t'(s_axis_tdata[7:6]);
    assign col_inc       = col_reg + COL_W'(1);

    always_comb
    begin
        if (map_columns_reg == '0)
        begin
            eff_cols = COL_W'(1);
        end
        else if (map_columns_reg > CLAMP_L)
        begin
            eff_cols = CLAMP_L;
        end
        else
        begin
            eff_cols = map_columns_reg;
        end
    end

    always_comb
    begin
        map_columns_next = cfg_wr_en ? cfg_wr_data : map_columns_reg;
        state_next       = state_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        lit_pending_next = lit_pending_reg;
        lit_count_next   = lit_count_reg;
        finished_next    = finished_reg;
        run_count_next   = run_count_reg;
        run_value_next   = run_value_reg;
        run_trunc_next   = run_trunc_reg;
        m_valid_next     = m_valid_reg && !m_axis_tready;
        out_value_next   = out_value_reg;
        out_col_next     = out_col_reg;
        out_row_next     = out_row_reg;
        out_last_next    = out_last_reg;
        out_done_next    = out_done_reg;
        out_trunc_next   = out_trunc_reg;
        run_go           = 1'b0;
        run_n            = '0;
        run_v            = '0;
        rearm            = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_axis_tuser)
                    begin
                        if (!finished_reg)
                        begin
                            run_trunc_next = 1'b1;
                            run_count_next = COUNT_W'(1);
                            state_next     = ST_RUN;
                        end
                        else
                        begin
                            rearm = 1'b1;
                        end
                    end
                    else if (!finished_reg)
                    begin
                        if (lit_pending_reg)
                        begin
                            lit_pending_next = 1'b0;
                            lit_count_next   = '0;
                            run_go           = 1'b1;
                            run_n            = lit_count_reg;
                            run_v            = s_axis_tdata;
                        end
                        else
                        begin
                            unique case (code)
                                CODE_LITERAL:
                                begin
                                    lit_pending_next = 1'b1;
                                    lit_count_next   = {1'b0, s_axis_tdata[5:0]} + COUNT_W'(1);
                                end
                                CODE_SHORT:
                                begin
                                    run_go = 1'b1;
                                    run_n  = COUNT_W'(s_axis_tdata[5:4]) + COUNT_W'(2);
                                    run_v  = BYTE_W'(s_axis_tdata[3:0]) + BYTE_W'(1);
                                end
                                CODE_ZERO:
                                begin
                                    run_go = 1'b1;
                                    run_n  = {1'b0, s_axis_tdata[5:0]};
                                end
                                CODE_SINGLE:
                                begin
                                    run_go = 1'b1;
                                    run_n  = COUNT_W'(1);
                                    run_v  = {2'b00, s_axis_tdata[5:0]};
                                end
                                default:
                                begin
                                    run_go = 1'b0;
                                end
                            endcase
                        end
                        if (run_go && (run_n != '0))
                        begin
                            run_count_next = run_n;
                            run_value_next = run_v;
                            run_trunc_next = 1'b0;
                            state_next     = ST_RUN;
                        end
                    end
                end
            end
            ST_RUN:
            begin
                if (slot_free)
                begin
                    m_valid_next   = 1'b1;
                    out_col_next   = col_reg[7:0];
                    out_row_next   = row_reg;
                    out_trunc_next = run_trunc_reg;
                    if (run_trunc_reg)
                    begin
                        out_value_next = '0;
                        out_last_next  = 1'b1;
                        out_done_next  = 1'b0;
                        run_trunc_next = 1'b0;
                        rearm          = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        out_value_next = run_value_reg;
                        out_done_next  = 1'b0;
                        run_count_next = run_count_reg - COUNT_W'(1);
                        row_next       = row_reg + ROW_W'(1);
                        if (row_reg == ROW_LAST)
                        begin
                            row_next = '0;
                            col_next = col_inc;
                            if (col_inc >= eff_cols)
                            begin
                                finished_next = 1'b1;
                                out_done_next = 1'b1;
                            end
                        end
                        out_last_next = (row_reg == ROW_LAST) || (run_count_reg == COUNT_W'(1));
                        if (out_last_next)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (rearm)
        begin
            col_next         = '0;
            row_next         = '0;
            lit_pending_next = 1'b0;
            lit_count_next   = '0;
            finished_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            map_columns_reg <= CFG_W'(1);
            col_reg         <= '0;
            row_reg         <= '0;
            lit_pending_reg <= 1'b0;
            lit_count_reg   <= '0;
            finished_reg    <= 1'b0;
            run_count_reg   <= '0;
            run_trunc_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            map_columns_reg <= map_columns_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            lit_pending_reg <= lit_pending_next;
            lit_count_reg   <= lit_count_next;
            finished_reg    <= finished_next;
            run_count_reg   <= run_count_next;
            run_trunc_reg   <= run_trunc_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_value_reg <= run_value_next;
        out_value_reg <= out_value_next;
        out_col_reg   <= out_col_next;
        out_row_reg   <= out_row_next;
        out_last_reg  <= out_last_next;
        out_done_reg  <= out_done_next;
        out_trunc_reg <= out_trunc_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {2'b00, out_row_reg, out_col_reg, out_value_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = {out_trunc_reg, out_done_reg};

`ifndef SYNTHESIS
    a_trunc_word: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tlast && !m_axis_tuser[0]
            && (m_axis_tdata[7:0] == 8'h00)))
        else $error("error word without last flag or with tile data");

    a_done_word: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tlast
            && (m_axis_tdata[21:16] == ROW_LAST)))
        else $error("map complete flagged away from the column end");

    a_run_live: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RUN) && !run_trunc_reg) |-> (!finished_reg
            && (run_count_reg != '0)))
        else $error("tile run active on a finished map or with no count");

    a_run_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RUN) && !slot_free) |=> ($stable(col_reg)
            && $stable(row_reg) && $stable(run_count_reg)))
        else $error("position advanced while the output word was stalled");
`endif

endmodule

// ===== bench/tile_stream_checker.sv =====
module tile_stream_checker
    import ctrle_pkg::*;
#(
    parameter int unsigned COLUMN_LIMIT = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_W-1:0]      cfg_wr_data,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [BYTE_W-1:0]     s_axis_tdata,
    input  logic                  s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  m_axis_tlast,
    input  logic [OUT_USER_W-1:0] m_axis_tuser,
    output int                    fail_count,
    output int                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]       tile;
        logic [7:0]       col;
        logic [ROW_W-1:0] row;
        logic             last;
        logic             done;
        logic             trunc;
    } tile_word_t;

    tile_word_t       expected_tiles[$];
    logic [CFG_W-1:0] map_cols;
    int               col_pos;
    int               row_pos;
    logic             literal_armed;
    int               literal_len;
    logic             map_full;

    function automatic int column_span();
        int c;
        c = int'(map_cols);
        if (c < 1)
            c = 1;
        if (c > COLUMN_LIMIT)
            c = COLUMN_LIMIT;
        return c;
    endfunction

    task automatic report(input string msg);
        $display("ERROR %0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic rearm();
        col_pos = 0;
        row_pos = 0;
        literal_armed = 1'b0;
        literal_len = 0;
        map_full = 1'b0;
    endtask

    // hold each tile back one step so the last one of the run can carry tlast
    task automatic emit_run(input int count, input logic [7:0] val);
        tile_word_t held;
        bit         have;
        int         n;
        have = 1'b0;
        n = count;
        while (n > 0 && !map_full)
        begin
            if (have)
                expected_tiles.push_back(held);
            held = '{val, col_pos[7:0], row_pos[ROW_W-1:0], 1'b0, 1'b0, 1'b0};
            have = 1'b1;
            n--;
            if (row_pos[ROW_W-1:0] == ROW_LAST)
            begin
                row_pos = 0;
                col_pos++;
                n = 0;
                if (col_pos >= column_span())
                begin
                    map_full = 1'b1;
                    held.done = 1'b1;
                end
            end
            else
                row_pos++;
        end
        if (have)
        begin
            held.last = 1'b1;
            expected_tiles.push_back(held);
        end
    endtask

    task automatic decode_word(input logic [7:0] b, input logic stream_end);
        int n;
        if (stream_end)
        begin
            if (!map_full)
                expected_tiles.push_back('{8'h00, col_pos[7:0], row_pos[ROW_W-1:0],
                                           1'b1, 1'b0, 1'b1});
            rearm();
        end
        else if (map_full)
            ;
        else if (literal_armed)
        begin
            n = literal_len;
            literal_armed = 1'b0;
            literal_len = 0;
            emit_run(n, b);
        end
        else
        begin
            case (code_t'(b[7:6]))
                CODE_LITERAL:
                begin
                    literal_armed = 1'b1;
                    literal_len = int'(b[5:0]) + 1;
                end
                CODE_SHORT:  emit_run(int'(b[5:4]) + 2, {4'h0, b[3:0]} + 8'd1);
                CODE_ZERO:   emit_run(int'(b[5:0]), 8'h00);
                default:     emit_run(1, {2'b00, b[5:0]});
            endcase
        end
    endtask

    task automatic check_tile();
        tile_word_t seen;
        tile_word_t want;
        seen = '{m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[21:16],
                 m_axis_tlast, m_axis_tuser[0], m_axis_tuser[1]};
        if (expected_tiles.size() == 0)
            report($sformatf("unexpected word val %h col %0d row %0d last %b done %b trunc %b",
                             seen.tile, seen.col, seen.row, seen.last, seen.done,
                             seen.trunc));
        else
        begin
            want = expected_tiles.pop_front();
            if (seen !== want)
                report($sformatf({"word val %h col %0d row %0d last %b done %b trunc %b,",
                                  " want val %h col %0d row %0d last %b done %b trunc %b"},
                                 seen.tile, seen.col, seen.row, seen.last, seen.done,
                                 seen.trunc, want.tile, want.col, want.row, want.last,
                                 want.done, want.trunc));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_cols = CFG_W'(1);
            rearm();
            expected_tiles.delete();
            fail_count = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_wr_en)
                map_cols = cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready)
                decode_word(s_axis_tdata, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready)
                check_tile();
            outstanding = expected_tiles.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
module tb
    import ctrle_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned COLUMN_LIMIT = 256;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_W-1:0]      cfg_wr_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    int                    fail_count;
    int                    outstanding;
    int                    in_calm;
    int                    out_calm;
    int                    words_sent;

    column_tile_rle_decoder #(.MAX_COLUMNS(COLUMN_LIMIT)) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    tile_stream_checker #(.COLUMN_LIMIT(COLUMN_LIMIT)) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("column_tile_rle_decoder: mismatch");
        $finish;
    end

    // mostly random gaps, with occasional stretches of back-to-back words
    function automatic int draw_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            calm = $urandom_range(5, 20);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    function automatic logic [7:0] random_code();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return {CODE_LITERAL, 6'($urandom_range(0, 63))};
            4, 5:       return {CODE_SHORT, 6'($urandom_range(0, 63))};
            6, 7:       return {CODE_ZERO, 6'($urandom_range(0, 63))};
            default:    return {CODE_SINGLE, 6'($urandom_range(0, 63))};
        endcase
    endfunction

    task automatic push_word(input logic [7:0] b, input logic stream_end);
        int gap;
        gap = draw_gap(in_calm);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = b;
        s_axis_tuser = stream_end;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        words_sent++;
    endtask

    // hold off input until every expected tile is out and the block settles
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_columns(input logic [CFG_W-1:0] v);
        cfg_wr_data = v;
        cfg_wr_en = 1'b1;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = draw_gap(out_calm);
            if (gap > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            @(negedge clk);
        end
    end

    initial
    begin
        logic [7:0] b;
        int         len;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        in_calm = 0;
        out_calm = 0;
        words_sent = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // zero columns acts as one column
        write_columns(9'd0);
        push_word(8'h3F, 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(8'hC5, 1'b0);
        push_word(8'h00, 1'b1);
        push_word(8'h00, 1'b0);
        push_word(8'h00, 1'b0);
        push_word(8'h7F, 1'b0);
        push_word(8'h40, 1'b0);
        push_word(8'h80, 1'b0);
        push_word(8'hC0, 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(8'hBF, 1'b0);
        push_word(8'hAA, 1'b1);
        push_word(8'h00, 1'b0);
        push_word(8'h55, 1'b1);
        push_word(8'hC1, 1'b0);
        push_word(8'hFF, 1'b1);
        drain();

        // widest count, then shrink below the current column
        write_columns(9'h1FF);
        push_word(8'h3F, 1'b0);
        push_word(8'h81, 1'b0);
        push_word(8'hC3, 1'b0);
        push_word(8'h41, 1'b0);
        drain();
        write_columns(9'd1);
        push_word(8'hBF, 1'b0);
        push_word(8'h00, 1'b1);

        while (words_sent < 105)
        begin
            drain();
            case ($urandom_range(0, 5))
                0:       write_columns(9'd0);
                1:       write_columns(9'd1);
                2:       write_columns(9'd2);
                3:       write_columns(9'd3);
                4:       write_columns(9'($urandom_range(4, 8)));
                default: write_columns(9'($urandom_range(257, 511)));
            endcase
            len = $urandom_range(6, 30);
            repeat (len)
            begin
                case ($urandom_range(0, 19))
                    0: push_word(8'($urandom_range(0, 255)), 1'b1);
                    1: push_word(8'($urandom_range(0, 255)), 1'b0);
                    default:
                    begin
                        b = random_code();
                        push_word(b, 1'b0);
                        if (b[7:6] == CODE_LITERAL)
                            push_word(8'($urandom_range(0, 255)), 1'b0);
                    end
                endcase
            end
            if ($urandom_range(0, 9) < 7)
                push_word(8'($urandom_range(0, 255)), 1'b1);
        end

        drain();
        repeat (10) @(negedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("column_tile_rle_decoder: match");
        else
            $display("column_tile_rle_decoder: mismatch");
        $finish;
    end

endmodule
